@@ design/rtp_reo_pkg.sv @@
// Shared constants, codes and types of the RTP sequence reorder buffer.
package rtp_reo_pkg;

    // Store geometry
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 2);
    localparam int HELD_W   = $clog2(CAPACITY + 1);

    // Field widths
    localparam int SEQ_W      = 16;
    localparam int SID_W      = 32;
    localparam int TAG_W      = 16;
    localparam int WIN_W      = 5;
    localparam int THR_W      = 8;
    localparam int LOSS_W     = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int ENTRY_W    = SEQ_W + TAG_W;
    localparam int SUM_W      = ((WIN_W > HELD_W) ? WIN_W : HELD_W) + 1;

    // Sequence space
    localparam logic [SEQ_W-1:0]  MAX_SEQ   = 16'hFFFF;
    localparam logic [SEQ_W-1:0]  HALF_SPAN = MAX_SEQ >> 1;
    localparam logic [LOSS_W-1:0] LOSS_MAX  = {LOSS_W{1'b1}};

    // Register reset values
    localparam logic [WIN_W-1:0] MIN_WINDOW_RST = 5'd4;
    localparam logic [WIN_W-1:0] MAX_WINDOW_RST = 5'd16;
    localparam logic [THR_W-1:0] LOSS_THR_RST   = 8'd10;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_WINDOW     = 2'd0,
        CFG_MAX_WINDOW     = 2'd1,
        CFG_LOSS_THRESHOLD = 2'd2
    } cfg_reg_t;

    // Result item kinds
    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // One store entry presented to the scan unit
    typedef struct packed {
        logic             start;
        logic             vld;
        logic             held;
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] tag;
        logic [IDX_W-1:0] idx;
    } scan_ent_t;

    // Trackers collected over one pass of the store
    typedef struct packed {
        logic             match;
        logic [IDX_W-1:0] match_idx;
        logic [TAG_W-1:0] match_tag;
        logic             ge;
        logic [SEQ_W-1:0] ge_seq;
        logic             any;
        logic [IDX_W-1:0] any_idx;
        logic [SEQ_W-1:0] any_seq;
        logic [TAG_W-1:0] any_tag;
        logic             free;
        logic [IDX_W-1:0] free_idx;
    } scan_res_t;

endpackage

@@ design/rtp_reo_if.sv @@
// Valid/ready channel interfaces for packet input and result output.
interface rtp_reo_in_if
    import rtp_reo_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SEQ_W-1:0] seq;
    logic [SID_W-1:0] stream_id;
    logic [TAG_W-1:0] packet_tag;

    modport source (output valid, output seq, output stream_id, output packet_tag,
                    input ready);
    modport sink   (input valid, input seq, input stream_id, input packet_tag,
                    output ready);
endinterface

interface rtp_reo_out_if
    import rtp_reo_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [SEQ_W-1:0]  out_seq;
    logic [TAG_W-1:0]  out_tag;
    logic              rejected;
    logic [LOSS_W-1:0] lost_count;
    logic              last;

    modport source (output valid, output kind, output out_seq, output out_tag,
                    output rejected, output lost_count, output last, input ready);
    modport sink   (input valid, input kind, input out_seq, input out_tag,
                    input rejected, input lost_count, input last, output ready);
endinterface

@@ design/rtp_sequence_reorder_buffer_core.sv @@
// Top level of the RTP sequence reorder buffer: sequencer, store and output register.
//
// Packets enter on pkt_in (seq, stream_id, packet_tag) with a valid/ready transfer
// and leave in sequence order on pkt_out. Each input produces zero or more release
// items (kind 0) followed by one status item (kind 1, last 1) carrying the reject
// flag and the saturating loss count. Registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce. The block takes one packet at
// a time; pkt_in.ready is high only between packets. Every search walks the
// whole store through one RAM read port and the shared compare unit, one entry
// a cycle. A full store adds one more search, run and duplicate pass to an
// accepted packet, and a stream change first flushes all held entries. The
// status item closes each packet; each release leaves as soon as the run or
// flush pass that found it ends. A single output register holds each result;
// while the receiver stalls, the sequencer waits at the next result.
// Reset empties the store, clears expected number, stream, reject run and loss
// count, and loads the register defaults (4, 16, 10); no clearing pass is needed.
module rtp_sequence_reorder_buffer_core
    import rtp_reo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rtp_reo_in_if.sink            pkt_in,
    rtp_reo_out_if.source         pkt_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FLUSH,
        S_FLUSH_OUT,
        S_WINDOW,
        S_DUP,
        S_STORE,
        S_SEARCH,
        S_RUN,
        S_RUN_OUT,
        S_STATUS
    } state_t;

    state_t              state_reg,     state_next;
    logic [CNT_W-1:0]    cnt_reg,       cnt_next;
    logic                force_reg,     force_next;
    logic [SEQ_W-1:0]    seq_in_reg,    seq_in_next;
    logic [TAG_W-1:0]    tag_in_reg,    tag_in_next;
    logic [SID_W-1:0]    stream_reg,    stream_next;
    logic [SEQ_W-1:0]    expected_reg,  expected_next;
    logic [WIN_W-1:0]    limit_reg,     limit_next;
    logic [THR_W-1:0]    run_reg,       run_next;
    logic [LOSS_W-1:0]   loss_reg,      loss_next;
    logic                rej_reg,       rej_next;
    logic [HELD_W-1:0]   held_cnt_reg,  held_cnt_next;
    logic [CAPACITY-1:0] valid_reg,     valid_next;
    logic [WIN_W-1:0]    min_win_reg,   min_win_next;
    logic [WIN_W-1:0]    max_win_reg,   max_win_next;
    logic [THR_W-1:0]    thr_reg,       thr_next;
    logic                pipe_vld_reg,  pipe_vld_next;
    logic                pipe_held_reg, pipe_held_next;
    logic [IDX_W-1:0]    pipe_idx_reg,  pipe_idx_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg,  out_kind_next;
    logic [SEQ_W-1:0]    out_seq_reg,   out_seq_next;
    logic [TAG_W-1:0]    out_tag_reg,   out_tag_next;
    logic                out_rej_reg,   out_rej_next;
    logic [LOSS_W-1:0]   out_lost_reg,  out_lost_next;
    logic                out_last_reg,  out_last_next;

    logic               scanning;
    logic               scan_done;
    logic               slot_free;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [SEQ_W-1:0]   scan_key;
    scan_ent_t          scan_ent;
    scan_res_t          scan_res;
    logic [SEQ_W-1:0]   diff_lo;
    logic [SEQ_W-1:0]   diff_hi;
    logic               rej;
    logic [THR_W-1:0]   run_inc;
    logic               pick_found;
    logic [SEQ_W-1:0]   pick_seq;
    logic [SUM_W-1:0]   lim_sum;
    logic [WIN_W-1:0]   lim_new;
    logic               hold_ok;

    // Entry store: sequence number above tag
    rtp_reo_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (scan_res.free_idx),
        .wdata ({seq_in_reg, tag_in_reg}),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Shared compare unit
    rtp_reo_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ent   (scan_ent),
        .key   (scan_key),
        .res   (scan_res)
    );

    // Scan control
    assign scanning  = (state_reg == S_FLUSH) || (state_reg == S_DUP) ||
                       (state_reg == S_SEARCH) || (state_reg == S_RUN);
    assign scan_done = (cnt_reg == CNT_W'(CAPACITY + 1));
    assign scan_key  = (state_reg == S_DUP) ? seq_in_reg : expected_reg;

    assign scan_ent.start = scanning && (cnt_reg == '0);
    assign scan_ent.vld   = pipe_vld_reg;
    assign scan_ent.held  = pipe_held_reg;
    assign scan_ent.seq   = ram_rdata[ENTRY_W-1:TAG_W];
    assign scan_ent.tag   = ram_rdata[TAG_W-1:0];
    assign scan_ent.idx   = pipe_idx_reg;

    // Window test against the expected number
    assign diff_lo = expected_reg - seq_in_reg;
    assign diff_hi = seq_in_reg - expected_reg;
    assign rej     = (seq_in_reg < expected_reg) ? (diff_lo < HALF_SPAN)
                                                 : (diff_hi > HALF_SPAN);
    assign run_inc = run_reg + THR_W'(1);

    // Release search pick and adaptive limit
    assign pick_found = scan_res.ge || scan_res.any;
    assign pick_seq   = scan_res.ge ? scan_res.ge_seq : scan_res.any_seq;
    assign hold_ok    = (SUM_W'(held_cnt_reg) <= SUM_W'(limit_reg));
    assign lim_sum    = SUM_W'(min_win_reg) + SUM_W'(held_cnt_reg);
    assign lim_new    = (lim_sum > SUM_W'(max_win_reg)) ? max_win_reg
                                                        : lim_sum[WIN_W-1:0];

    assign slot_free = !out_valid_reg || pkt_out.ready;
    assign ram_we    = (state_reg == S_STORE);

    // Ports
    assign pkt_in.ready       = (state_reg == S_IDLE);
    assign pkt_out.valid      = out_valid_reg;
    assign pkt_out.kind       = out_kind_reg;
    assign pkt_out.out_seq    = out_seq_reg;
    assign pkt_out.out_tag    = out_tag_reg;
    assign pkt_out.rejected   = out_rej_reg;
    assign pkt_out.lost_count = out_lost_reg;
    assign pkt_out.last       = out_last_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        force_next     = force_reg;
        seq_in_next    = seq_in_reg;
        tag_in_next    = tag_in_reg;
        stream_next    = stream_reg;
        expected_next  = expected_reg;
        limit_next     = limit_reg;
        run_next       = run_reg;
        loss_next      = loss_reg;
        rej_next       = rej_reg;
        held_cnt_next  = held_cnt_reg;
        valid_next     = valid_reg;
        min_win_next   = min_win_reg;
        max_win_next   = max_win_reg;
        thr_next       = thr_reg;
        out_valid_next = out_valid_reg && !pkt_out.ready;
        out_kind_next  = out_kind_reg;
        out_seq_next   = out_seq_reg;
        out_tag_next   = out_tag_reg;
        out_rej_next   = out_rej_reg;
        out_lost_next  = out_lost_reg;
        out_last_next  = out_last_reg;

        // Issue one store read per cycle while walking
        pipe_vld_next  = scanning && (cnt_reg < CNT_W'(CAPACITY));
        pipe_idx_next  = cnt_reg[IDX_W-1:0];
        pipe_held_next = valid_reg[cnt_reg[IDX_W-1:0]];
        if (scanning)
        begin
            cnt_next = scan_done ? '0 : cnt_reg + CNT_W'(1);
        end

        // Register writes
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_MIN_WINDOW:     min_win_next = cfg_data[WIN_W-1:0];
                CFG_MAX_WINDOW:     max_win_next = cfg_data[WIN_W-1:0];
                CFG_LOSS_THRESHOLD: thr_next     = cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (pkt_in.valid)
                begin
                    seq_in_next = pkt_in.seq;
                    tag_in_next = pkt_in.packet_tag;
                    if (pkt_in.stream_id != stream_reg)
                    begin
                        stream_next = pkt_in.stream_id;
                        state_next  = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_WINDOW;
                    end
                end
            end

            // Drain the store in ascending order, then restart on the new stream
            S_FLUSH:
            begin
                if (scan_done)
                begin
                    if (scan_res.any)
                    begin
                        state_next = S_FLUSH_OUT;
                    end
                    else
                    begin
                        expected_next = seq_in_reg;
                        limit_next    = min_win_reg;
                        state_next    = S_WINDOW;
                    end
                end
            end

            S_FLUSH_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next               = 1'b1;
                    out_kind_next                = KIND_RELEASE;
                    out_seq_next                 = scan_res.any_seq;
                    out_tag_next                 = scan_res.any_tag;
                    out_rej_next                 = 1'b0;
                    out_lost_next                = '0;
                    out_last_next                = 1'b0;
                    valid_next[scan_res.any_idx] = 1'b0;
                    held_cnt_next                = held_cnt_reg - HELD_W'(1);
                    state_next                   = S_FLUSH;
                end
            end

            // Reject outside the window, count loss events
            S_WINDOW:
            begin
                rej_next = rej;
                if (rej)
                begin
                    if (run_inc >= thr_reg)
                    begin
                        run_next = '0;
                        if (loss_reg != LOSS_MAX)
                        begin
                            loss_next = loss_reg + LOSS_W'(1);
                        end
                    end
                    else
                    begin
                        run_next = run_inc;
                    end
                    state_next = S_STATUS;
                end
                else
                begin
                    run_next   = '0;
                    state_next = S_DUP;
                end
            end

            // Look for a duplicate and a free slot
            S_DUP:
            begin
                if (scan_done)
                begin
                    if (scan_res.match)
                    begin
                        state_next = S_SEARCH;
                    end
                    else if (held_cnt_reg == HELD_W'(CAPACITY))
                    begin
                        force_next = 1'b1;
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        state_next = S_STORE;
                    end
                end
            end

            S_STORE:
            begin
                valid_next[scan_res.free_idx] = 1'b1;
                held_cnt_next                 = held_cnt_reg + HELD_W'(1);
                state_next                    = S_SEARCH;
            end

            // Pick the next number to release from, or hold
            S_SEARCH:
            begin
                if (scan_done)
                begin
                    if (!pick_found ||
                        ((pick_seq != expected_reg) && !force_reg && hold_ok))
                    begin
                        force_next = 1'b0;
                        state_next = force_reg ? S_DUP : S_STATUS;
                    end
                    else
                    begin
                        expected_next = pick_seq;
                        state_next    = S_RUN;
                    end
                end
            end

            // Release the consecutive run starting at the expected number
            S_RUN:
            begin
                if (scan_done)
                begin
                    if (scan_res.match)
                    begin
                        state_next = S_RUN_OUT;
                    end
                    else
                    begin
                        limit_next = lim_new;
                        force_next = 1'b0;
                        state_next = force_reg ? S_DUP : S_STATUS;
                    end
                end
            end

            S_RUN_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next                 = 1'b1;
                    out_kind_next                  = KIND_RELEASE;
                    out_seq_next                   = expected_reg;
                    out_tag_next                   = scan_res.match_tag;
                    out_rej_next                   = 1'b0;
                    out_lost_next                  = '0;
                    out_last_next                  = 1'b0;
                    valid_next[scan_res.match_idx] = 1'b0;
                    held_cnt_next                  = held_cnt_reg - HELD_W'(1);
                    expected_next                  = expected_reg + SEQ_W'(1);
                    state_next                     = S_RUN;
                end
            end

            S_STATUS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_STATUS;
                    out_seq_next   = '0;
                    out_tag_next   = '0;
                    out_rej_next   = rej_reg;
                    out_lost_next  = loss_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            force_reg     <= 1'b0;
            seq_in_reg    <= '0;
            tag_in_reg    <= '0;
            stream_reg    <= '0;
            expected_reg  <= '0;
            limit_reg     <= MIN_WINDOW_RST;
            run_reg       <= '0;
            loss_reg      <= '0;
            rej_reg       <= 1'b0;
            held_cnt_reg  <= '0;
            valid_reg     <= '0;
            min_win_reg   <= MIN_WINDOW_RST;
            max_win_reg   <= MAX_WINDOW_RST;
            thr_reg       <= LOSS_THR_RST;
            pipe_vld_reg  <= 1'b0;
            pipe_held_reg <= 1'b0;
            pipe_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_RELEASE;
            out_seq_reg   <= '0;
            out_tag_reg   <= '0;
            out_rej_reg   <= 1'b0;
            out_lost_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            force_reg     <= force_next;
            seq_in_reg    <= seq_in_next;
            tag_in_reg    <= tag_in_next;
            stream_reg    <= stream_next;
            expected_reg  <= expected_next;
            limit_reg     <= limit_next;
            run_reg       <= run_next;
            loss_reg      <= loss_next;
            rej_reg       <= rej_next;
            held_cnt_reg  <= held_cnt_next;
            valid_reg     <= valid_next;
            min_win_reg   <= min_win_next;
            max_win_reg   <= max_win_next;
            thr_reg       <= thr_next;
            pipe_vld_reg  <= pipe_vld_next;
            pipe_held_reg <= pipe_held_next;
            pipe_idx_reg  <= pipe_idx_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_seq_reg   <= out_seq_next;
            out_tag_reg   <= out_tag_next;
            out_rej_reg   <= out_rej_next;
            out_lost_reg  <= out_lost_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Held count tracks the valid bits
    a_held_count: assert property (@(posedge clk) disable iff (!rst_n)
        held_cnt_reg == HELD_W'($countones(valid_reg)))
        else $error("held count out of step with valid bits");

    // A store always lands in a slot found free
    a_store_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STORE) |-> (scan_res.free && !valid_reg[scan_res.free_idx]))
        else $error("store into an occupied slot");

    // A run release always takes a held entry
    a_run_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN_OUT) |-> (scan_res.match && valid_reg[scan_res.match_idx]))
        else $error("run release of an empty slot");

    // A flush release always takes a held entry
    a_flush_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH_OUT) |-> (scan_res.any && valid_reg[scan_res.any_idx]))
        else $error("flush release of an empty slot");

endmodule

@@ design/rtp_reo_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rtp_reo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ design/rtp_reo_scan.sv @@
// Shared compare unit: walks store entries and tracks match, least and free slot.
module rtp_reo_scan
    import rtp_reo_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  scan_ent_t        ent,
    input  logic [SEQ_W-1:0] key,
    output scan_res_t        res
);

    scan_res_t res_reg;
    scan_res_t res_next;

    assign res = res_reg;

    // Fold one entry into the trackers
    always_comb
    begin
        res_next = res_reg;
        if (ent.start)
        begin
            res_next.match = 1'b0;
            res_next.ge    = 1'b0;
            res_next.any   = 1'b0;
            res_next.free  = 1'b0;
        end
        else if (ent.vld)
        begin
            if (ent.held)
            begin
                if (!res_reg.match && (ent.seq == key))
                begin
                    res_next.match     = 1'b1;
                    res_next.match_idx = ent.idx;
                    res_next.match_tag = ent.tag;
                end
                if ((ent.seq >= key) && (!res_reg.ge || (ent.seq < res_reg.ge_seq)))
                begin
                    res_next.ge     = 1'b1;
                    res_next.ge_seq = ent.seq;
                end
                if (!res_reg.any || (ent.seq < res_reg.any_seq))
                begin
                    res_next.any     = 1'b1;
                    res_next.any_idx = ent.idx;
                    res_next.any_seq = ent.seq;
                    res_next.any_tag = ent.tag;
                end
            end
            else if (!res_reg.free)
            begin
                res_next.free     = 1'b1;
                res_next.free_idx = ent.idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

endmodule
